@@ src/ssr_pkg.sv @@
package ssr_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int SITE_WIDTH    = 24;
    localparam int CFG_WIDTH     = 24;
    localparam int CORDIC_STAGES = 20;
    localparam int SAMPLE_FRAC   = 20;
    localparam int DP_FRAC       = 36;
    localparam int GAIN_FRAC     = 30;
    localparam int GAIN_SHIFT    = SAMPLE_FRAC + GAIN_FRAC - DP_FRAC;
    localparam int OUT_SHIFT     = DP_FRAC - SAMPLE_FRAC;
    localparam int DP_WIDTH      = SAMPLE_WIDTH + OUT_SHIFT + 4;
    localparam int ANGLE_WIDTH   = 48;
    localparam int MAG_SHIFT     = 2 * SAMPLE_FRAC - 16;
    localparam int M16_WIDTH     = 2 * SAMPLE_WIDTH + 1 - MAG_SHIFT;
    localparam int GM_WIDTH      = CFG_WIDTH + M16_WIDTH + 1;
    localparam int SUM_WIDTH     = GM_WIDTH - 16 + 1;
    localparam int OPND_WIDTH    = 32;
    localparam int PROD_WIDTH    = CFG_WIDTH + 1 + OPND_WIDTH;
    localparam int RED_WIDTH     = 63;
    localparam int RED_STAGES    = 16;
    localparam int FRONT_DEPTH   = 7 + RED_STAGES + 2;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_WIDTH    = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [ANGLE_WIDTH-1:0] PI_Q44         = 48'sh3243F6A8885A;
    localparam logic signed [ANGLE_WIDTH-1:0] TWO_PI_Q44     = PI_Q44 * 2;
    localparam logic signed [ANGLE_WIDTH-1:0] HALF_PI_Q44    = PI_Q44 / 2;
    localparam logic signed [ANGLE_WIDTH-1:0] QUARTER_PI_Q44 = 48'sh0C90FDAA2217;
    localparam logic signed [SUM_WIDTH-1:0]   SUM_LIMIT      = SUM_WIDTH'(64'h7FFFFFFF);

    localparam logic [0:0] CFG_TIME_STEP   = 1'b0;
    localparam logic [0:0] CFG_INTERACTION = 1'b1;

    typedef struct packed {
        logic signed [DP_WIDTH-1:0]    x;
        logic signed [DP_WIDTH-1:0]    y;
        logic signed [ANGLE_WIDTH-1:0] z;
    } t_rot_word;

    function automatic logic [63:0] ssr_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] ssr_isqrt(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bt;
        n   = n_in;
        res = '0;
        bt  = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (bt > n) begin
                bt = bt >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (bt != 0) begin
                if (n >= res + bt) begin
                    n   = n - (res + bt);
                    res = (res >> 1) + bt;
                end else begin
                    res = res >> 1;
                end
                bt = bt >> 2;
            end
        end
        return res;
    endfunction

    function automatic logic signed [63:0] ssr_atan_q44(input int i);
        logic signed [63:0] sum;
        logic signed [63:0] term;
        int e;
        sum = '0;
        if (i == 0) begin
            return 64'(QUARTER_PI_Q44);
        end
        for (int k = 0; k < 31; k++) begin
            e = i * (2 * k + 1);
            if (e <= 60) begin
                term = $signed(ssr_udiv(64'd1 << (60 - e), 64'(2 * k + 1)));
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
        end
        return (sum + 64'sd32768) >>> 16;
    endfunction

    function automatic logic [63:0] ssr_inv_gain();
        logic [63:0] p;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            p = p + (p >> (2 * i));
        end
        return ssr_udiv(64'd1 << 60, ssr_isqrt(p));
    endfunction

    localparam logic signed [31:0] INV_GAIN = $signed(32'(ssr_inv_gain()));

endpackage

@@ src/ssr_front.sv @@
module ssr_front
    import ssr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_imag,
    input  logic signed [SITE_WIDTH-1:0]   i_site_value,
    input  logic        [CFG_WIDTH-1:0]    i_time_step,
    input  logic signed [CFG_WIDTH-1:0]    i_interaction,
    input  logic                           i_queue_full,
    output logic                           o_push,
    output t_rot_word                      o_word
);

    localparam int SQ_WIDTH = 2 * SAMPLE_WIDTH;
    localparam int XG_WIDTH = SAMPLE_WIDTH + 32;
    localparam logic signed [RED_WIDTH-1:0] TWO_PI_RED = 63'(TWO_PI_Q44);

    logic f_en;

    logic [FRONT_DEPTH-1:0] r_valid;

    logic                           r_op1, r_op2, r_op3, r_op4, r_op5, r_op6;
    logic signed [SAMPLE_WIDTH-1:0] r_re1, r_im1;
    logic signed [SITE_WIDTH-1:0]   r_site1, r_site2, r_site3, r_site4;
    logic signed [SQ_WIDTH-1:0]     r_rr2, r_ii2;
    logic signed [XG_WIDTH-1:0]     r_xg2, r_yg2;
    logic        [M16_WIDTH-1:0]    r_m16_3;
    logic signed [GM_WIDTH-1:0]     r_gm4;
    logic signed [OPND_WIDTH-1:0]   r_opnd5;
    logic signed [PROD_WIDTH-1:0]   r_prod6;
    logic signed [DP_WIDTH-1:0]     r_x3, r_y3, r_x4, r_y4, r_x5, r_y5, r_x6, r_y6;
    logic signed [RED_WIDTH-1:0]    r_red [RED_STAGES+1];
    logic signed [DP_WIDTH-1:0]     r_rx  [RED_STAGES+1];
    logic signed [DP_WIDTH-1:0]     r_ry  [RED_STAGES+1];
    logic signed [ANGLE_WIDTH-1:0]  r_zf, r_zp;
    logic signed [DP_WIDTH-1:0]     r_xf, r_yf, r_xp, r_yp;

    logic        [SQ_WIDTH:0]       w_mag;
    logic signed [SUM_WIDTH-1:0]    w_sum;
    logic signed [OPND_WIDTH-1:0]   w_s;
    logic signed [RED_WIDTH-1:0]    w_ph;
    logic signed [ANGLE_WIDTH-1:0]  w_r;

    assign f_en       = !(r_valid[FRONT_DEPTH-1] && i_queue_full);
    assign o_in_stall = !f_en;
    assign o_push     = r_valid[FRONT_DEPTH-1] && !i_queue_full;
    assign o_word     = '{x: r_xp, y: r_yp, z: r_zp};

    always_comb begin
        w_mag = {1'b0, r_rr2} + {1'b0, r_ii2};
        w_sum = SUM_WIDTH'(r_site4) + SUM_WIDTH'(r_gm4 >>> 16);
        if (w_sum > SUM_LIMIT) begin
            w_s = OPND_WIDTH'(SUM_LIMIT);
        end else if (w_sum < -SUM_LIMIT) begin
            w_s = OPND_WIDTH'(-SUM_LIMIT);
        end else begin
            w_s = OPND_WIDTH'(w_sum);
        end
        if (r_op6) begin
            w_ph = RED_WIDTH'(r_prod6) <<< 4;
        end else begin
            w_ph = RED_WIDTH'(r_prod6) <<< 2;
        end
        w_r = ANGLE_WIDTH'(r_red[RED_STAGES]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (f_en) begin
            r_valid <= {r_valid[FRONT_DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r_op1   <= i_operation;
            r_re1   <= i_psi_real;
            r_im1   <= i_psi_imag;
            r_site1 <= i_site_value;

            r_op2   <= r_op1;
            r_site2 <= r_site1;
            r_rr2   <= SQ_WIDTH'(r_re1) * SQ_WIDTH'(r_re1);
            r_ii2   <= SQ_WIDTH'(r_im1) * SQ_WIDTH'(r_im1);
            r_xg2   <= XG_WIDTH'(r_re1) * XG_WIDTH'(INV_GAIN);
            r_yg2   <= XG_WIDTH'(r_im1) * XG_WIDTH'(INV_GAIN);

            r_op3   <= r_op2;
            r_site3 <= r_site2;
            r_m16_3 <= M16_WIDTH'(w_mag >> MAG_SHIFT);
            r_x3    <= DP_WIDTH'(r_xg2 >>> GAIN_SHIFT);
            r_y3    <= DP_WIDTH'(r_yg2 >>> GAIN_SHIFT);

            r_op4   <= r_op3;
            r_site4 <= r_site3;
            r_gm4   <= GM_WIDTH'(i_interaction) * $signed({{(GM_WIDTH-M16_WIDTH){1'b0}}, r_m16_3});
            r_x4    <= r_x3;
            r_y4    <= r_y3;

            r_op5   <= r_op4;
            r_opnd5 <= r_op4 ? w_s : OPND_WIDTH'(r_site4);
            r_x5    <= r_x4;
            r_y5    <= r_y4;

            r_op6   <= r_op5;
            r_prod6 <= $signed({{(PROD_WIDTH-CFG_WIDTH){1'b0}}, i_time_step})
                       * PROD_WIDTH'(r_opnd5);
            r_x6    <= r_x5;
            r_y6    <= r_y5;

            r_red[0] <= (w_ph < 0) ? w_ph + (TWO_PI_RED <<< (RED_STAGES - 2)) : w_ph;
            r_rx[0]  <= r_x6;
            r_ry[0]  <= r_y6;

            if (w_r >= PI_Q44) begin
                r_zf <= TWO_PI_Q44 - w_r;
            end else begin
                r_zf <= -w_r;
            end
            r_xf <= r_rx[RED_STAGES];
            r_yf <= r_ry[RED_STAGES];

            if (r_zf > HALF_PI_Q44) begin
                r_xp <= -r_yf;
                r_yp <= r_xf;
                r_zp <= r_zf - HALF_PI_Q44;
            end else if (r_zf < -HALF_PI_Q44) begin
                r_xp <= r_yf;
                r_yp <= -r_xf;
                r_zp <= r_zf + HALF_PI_Q44;
            end else begin
                r_xp <= r_xf;
                r_yp <= r_yf;
                r_zp <= r_zf;
            end
        end
    end

    for (genvar j = 0; j < RED_STAGES; j++) begin : g_reduce
        localparam logic signed [RED_WIDTH-1:0] STEP = TWO_PI_RED <<< (RED_STAGES - 1 - j);

        always_ff @(posedge i_clk) begin
            if (f_en) begin
                if (r_red[j] >= STEP) begin
                    r_red[j+1] <= r_red[j] - STEP;
                end else begin
                    r_red[j+1] <= r_red[j];
                end
                r_rx[j+1] <= r_rx[j];
                r_ry[j+1] <= r_ry[j];
            end
        end
    end

endmodule

@@ src/ssr_queue.sv @@
module ssr_queue
    import ssr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_rot_word i_word,
    output logic      o_full,
    input  logic      i_pop,
    output t_rot_word o_word,
    output logic      o_valid
);

    t_rot_word r_mem [QUEUE_DEPTH];

    logic [QPTR_WIDTH-1:0] r_wr_ptr;
    logic [QPTR_WIDTH-1:0] r_rd_ptr;
    logic [QCNT_WIDTH-1:0] r_count;

    assign o_full  = (r_count == QCNT_WIDTH'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

@@ src/ssr_back.sv @@
module ssr_back
    import ssr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_rot_word                      i_word,
    input  logic                           i_queue_valid,
    output logic                           o_pop,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_rotated_real,
    output logic signed [SAMPLE_WIDTH-1:0] o_rotated_imag
);

    localparam int RND_WIDTH = DP_WIDTH + 1 - OUT_SHIFT;

    function automatic logic signed [SAMPLE_WIDTH-1:0] finish(
        input logic signed [DP_WIDTH-1:0] v
    );
        logic signed [DP_WIDTH:0]    sum;
        logic signed [RND_WIDTH-1:0] q;
        logic signed [RND_WIDTH-1:0] hi;
        logic signed [RND_WIDTH-1:0] lo;
        hi  = RND_WIDTH'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
        lo  = -hi - RND_WIDTH'(1);
        sum = (DP_WIDTH+1)'(v) + (DP_WIDTH+1)'(1 << (OUT_SHIFT - 1));
        q   = RND_WIDTH'(sum >>> OUT_SHIFT);
        if (q > hi) begin
            q = hi;
        end else if (q < lo) begin
            q = lo;
        end
        return SAMPLE_WIDTH'(q);
    endfunction

    logic b_en;

    logic [CORDIC_STAGES-1:0]      r_valid;
    logic signed [DP_WIDTH-1:0]    r_x [CORDIC_STAGES];
    logic signed [DP_WIDTH-1:0]    r_y [CORDIC_STAGES];
    logic signed [ANGLE_WIDTH-1:0] r_z [CORDIC_STAGES];
    logic                          r_out_valid;

    assign b_en        = !(r_out_valid && i_out_stall);
    assign o_pop       = i_queue_valid && b_en;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else if (b_en) begin
            r_valid     <= {r_valid[CORDIC_STAGES-2:0], i_queue_valid};
            r_out_valid <= r_valid[CORDIC_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            o_rotated_real <= finish(r_x[CORDIC_STAGES-1]);
            o_rotated_imag <= finish(r_y[CORDIC_STAGES-1]);
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
        localparam logic signed [ANGLE_WIDTH-1:0] ANG = ANGLE_WIDTH'(ssr_atan_q44(i));

        logic signed [DP_WIDTH-1:0]    x_in;
        logic signed [DP_WIDTH-1:0]    y_in;
        logic signed [ANGLE_WIDTH-1:0] z_in;

        if (i == 0) begin : g_head
            assign x_in = i_word.x;
            assign y_in = i_word.y;
            assign z_in = i_word.z;
        end else begin : g_chain
            assign x_in = r_x[i-1];
            assign y_in = r_y[i-1];
            assign z_in = r_z[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (b_en) begin
                if (z_in >= 0) begin
                    r_x[i] <= x_in - (y_in >>> i);
                    r_y[i] <= y_in + (x_in >>> i);
                    r_z[i] <= z_in - ANG;
                end else begin
                    r_x[i] <= x_in + (y_in >>> i);
                    r_y[i] <= y_in - (x_in >>> i);
                    r_z[i] <= z_in + ANG;
                end
            end
        end
    end

endmodule

@@ src/split_step_phase_rotator.sv @@
// Rotates one complex Q4.20 sample per clock, unless stalled, by exp(-i*phase), with the
// phase taken from the kinetic or the potential-plus-interaction term and reduced modulo
// two pi. Words are accepted at one per cycle while o_in_stall is low; the edge that
// accepts a word loads the first of 25 stages of phase arithmetic and modulo reduction,
// then the word goes into the four-word queue, and 20 CORDIC stages and the rounding
// register follow. The front and the CORDIC back end stall separately, so behind a
// stalled output input words keep being taken until the 25 front stages and the
// four-word queue are full.
module split_step_phase_rotator
    import ssr_pkg::*;
(
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_write,
    input  logic [0:0]                     i_cfg_index,
    input  logic [CFG_WIDTH-1:0]           i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_real,
    input  logic signed [SAMPLE_WIDTH-1:0] i_psi_imag,
    input  logic signed [SITE_WIDTH-1:0]   i_site_value,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_rotated_real,
    output logic signed [SAMPLE_WIDTH-1:0] o_rotated_imag
);

    logic        [CFG_WIDTH-1:0] r_time_step;
    logic signed [CFG_WIDTH-1:0] r_interaction;

    logic      queue_full;
    logic      queue_valid;
    logic      push;
    logic      pop;
    t_rot_word front_word;
    t_rot_word head_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step   <= '0;
            r_interaction <= '0;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_TIME_STEP:   r_time_step   <= i_cfg_data;
                CFG_INTERACTION: r_interaction <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    ssr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_psi_real    (i_psi_real),
        .i_psi_imag    (i_psi_imag),
        .i_site_value  (i_site_value),
        .i_time_step   (r_time_step),
        .i_interaction (r_interaction),
        .i_queue_full  (queue_full),
        .o_push        (push),
        .o_word        (front_word)
    );

    ssr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (front_word),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_word  (head_word),
        .o_valid (queue_valid)
    );

    ssr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_word         (head_word),
        .i_queue_valid  (queue_valid),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_rotated_real (o_rotated_real),
        .o_rotated_imag (o_rotated_imag)
    );

endmodule

@@ tb/testbench.sv @@
module testbench;
    import ssr_pkg::*;

    typedef struct {
        logic                           op;
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic signed [SITE_WIDTH-1:0]   site;
    } t_sample;

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
    } t_rotated;

    localparam longint PI_FIX      = 64'sh3243F6A8885A;
    localparam longint TWO_PI_FIX  = 2 * PI_FIX;
    localparam longint HALF_PI_FIX = PI_FIX / 2;
    localparam int     CYCLE_LIMIT = 300000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_write = 1'b0;
    logic [0:0]                     i_cfg_index = CFG_TIME_STEP;
    logic [CFG_WIDTH-1:0]           i_cfg_data = '0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_stall;
    logic                           i_operation = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] i_psi_real = '0;
    logic signed [SAMPLE_WIDTH-1:0] i_psi_imag = '0;
    logic signed [SITE_WIDTH-1:0]   i_site_value = '0;
    logic                           o_out_valid;
    logic                           i_out_stall = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] o_rotated_real;
    logic signed [SAMPLE_WIDTH-1:0] o_rotated_imag;

    split_step_phase_rotator dut (.*);

    always #10 i_clk = ~i_clk;

    longint   angle_lut[CORDIC_STAGES];
    longint   gain_recip;
    longint   dt_reg;
    longint   coupling_reg;
    t_sample  pending_words[$];
    t_rotated expected_words[$];
    int       errors = 0;
    int       cycles = 0;
    bit       quiet = 1'b0;
    bit       hold_request = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    int       long_hold = 0;

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint unsigned root_of(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic void build_constants();
        longint unsigned p;
        longint sum;
        longint unsigned term;
        int e;
        p = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) begin
                angle_lut[i] = 64'sh0C90FDAA2217;
            end else begin
                sum = 0;
                for (int k = 0; k < 64; k++) begin
                    e = i * (2 * k + 1);
                    if (e <= 60) begin
                        term = (64'd1 << (60 - e)) / longint'(2 * k + 1);
                        sum = (k % 2 == 1) ? sum - longint'(term) : sum + longint'(term);
                    end
                end
                angle_lut[i] = (sum + 64'sd32768) >>> 16;
            end
            p = p + (p >> (2 * i));
        end
        gain_recip = longint'((64'd1 << 60) / root_of(p));
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(longint v);
        longint r;
        longint top;
        top = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
        r = floor_shift(v + (64'sd1 <<< (DP_FRAC - SAMPLE_FRAC - 1)), DP_FRAC - SAMPLE_FRAC);
        if (r > top) r = top;
        if (r < -top - 1) r = -top - 1;
        return r[SAMPLE_WIDTH-1:0];
    endfunction

    function automatic t_rotated rotate_sample(t_sample w);
        longint re, im, site, ph, r, z, x, y, t, dx, dy, mag, s;
        t_rotated res;
        re = w.re;
        im = w.im;
        site = w.site;
        if (!w.op) begin
            ph = dt_reg * site * 4;
        end else begin
            mag = re * re + im * im;
            s = site + floor_shift(coupling_reg * (mag >>> (2 * SAMPLE_FRAC - 16)), 16);
            if (s > 64'sh7FFFFFFF) s = 64'sh7FFFFFFF;
            if (s < -64'sh7FFFFFFF) s = -64'sh7FFFFFFF;
            ph = dt_reg * s * 16;
        end
        r = ph % TWO_PI_FIX;
        if (r < 0) r = r + TWO_PI_FIX;
        if (r >= PI_FIX) r = r - TWO_PI_FIX;
        z = -r;
        x = floor_shift(re * gain_recip, SAMPLE_FRAC + GAIN_FRAC - DP_FRAC);
        y = floor_shift(im * gain_recip, SAMPLE_FRAC + GAIN_FRAC - DP_FRAC);
        if (z > HALF_PI_FIX) begin
            t = x; x = -y; y = t;
            z = z - HALF_PI_FIX;
        end else if (z < -HALF_PI_FIX) begin
            t = x; x = y; y = -t;
            z = z + HALF_PI_FIX;
        end
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - angle_lut[i];
            end else begin
                x = x + dx; y = y - dy; z = z + angle_lut[i];
            end
        end
        res.re = round_sat(x);
        res.im = round_sat(y);
        return res;
    endfunction

    function automatic logic [23:0] rand_part(bit full);
        if (full) return 24'($urandom);
        return 24'($urandom_range(0, 4194303) - 2097152);
    endfunction

    // Sender: a new word is loaded only when the previous one was taken or none is shown.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_words.push_back(rotate_sample('{i_operation, i_psi_real,
                                                         i_psi_imag, i_site_value}));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    t_sample w;
                    w = pending_words.pop_front();
                    i_in_valid <= 1'b1;
                    i_operation <= w.op;
                    i_psi_real <= w.re;
                    i_psi_imag <= w.im;
                    i_site_value <= w.site;
                    if (!quiet && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 6);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each taken result and drives the output stall.
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            if (expected_words.size() == 0) begin
                $error("unexpected word: real %0d imag %0d", o_rotated_real, o_rotated_imag);
                errors++;
            end else begin
                t_rotated e;
                e = expected_words.pop_front();
                if (o_rotated_real !== e.re) begin
                    $error("rotated_real expected %0d actual %0d", e.re, o_rotated_real);
                    errors++;
                end
                if (o_rotated_imag !== e.im) begin
                    $error("rotated_imag expected %0d actual %0d", e.im, o_rotated_imag);
                    errors++;
                end
            end
        end
        if (hold_request && long_hold == 0) begin
            hold_request <= 1'b0;
            long_hold <= 200;
            i_out_stall <= 1'b1;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            i_out_stall <= (long_hold > 1);
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            recv_gap <= $urandom_range(0, 5);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [CFG_WIDTH-1:0] val);
        @(posedge i_clk);
        i_cfg_write <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_write <= 1'b0;
        if (idx == CFG_TIME_STEP) dt_reg = longint'({1'b0, val});
        else coupling_reg = longint'($signed(val));
    endtask

    task automatic drain();
        while (pending_words.size() > 0 || i_in_valid || expected_words.size() > 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic random_words(int count);
        t_sample w;
        bit full;
        for (int n = 0; n < count; n++) begin
            full = ($urandom_range(0, 4) == 0);
            w.op = $urandom_range(0, 1);
            w.re = rand_part(full);
            w.im = rand_part(full);
            w.site = 24'($urandom);
            pending_words.push_back(w);
        end
    endtask

    initial begin
        logic signed [23:0] edges[4];
        edges = '{24'sh7FFFFF, -24'sh800000, 24'sh0, -24'sh1};
        build_constants();
        dt_reg = 0;
        coupling_reg = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // With a zero time step only the gain-compensated CORDIC acts on the word.
        random_words(20);
        drain();

        write_reg(CFG_TIME_STEP, 24'h123456);
        write_reg(CFG_INTERACTION, 24'h010000);
        for (int a = 0; a < 4; a++) begin
            pending_words.push_back('{a[0], edges[a], edges[3 - a], edges[a]});
            pending_words.push_back('{~a[0], edges[a], edges[a], edges[(a + 1) % 4]});
        end
        pending_words.push_back('{1'b1, 24'sh100000, 24'sh0, 24'sh0});
        pending_words.push_back('{1'b0, 24'sh100000, 24'sh0, 24'sh10000});
        random_words(200);
        hold_request = 1'b1;
        random_words(100);
        drain();

        write_reg(CFG_TIME_STEP, 24'hFFFFFF);
        write_reg(CFG_INTERACTION, 24'h7FFFFF);
        random_words(250);
        drain();

        write_reg(CFG_INTERACTION, 24'h800000);
        random_words(250);
        drain();

        for (int p = 0; p < 2; p++) begin
            write_reg(CFG_TIME_STEP, 24'($urandom));
            write_reg(CFG_INTERACTION, 24'($urandom));
            random_words(200);
            drain();
        end

        write_reg(CFG_TIME_STEP, 24'h000001);
        write_reg(CFG_INTERACTION, 24'($urandom));
        quiet = 1'b1;
        random_words(150);
        drain();

        if (errors == 0 && expected_words.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/ssr_pkg.sv
src/ssr_front.sv
src/ssr_queue.sv
src/ssr_back.sv
src/split_step_phase_rotator.sv
tb/testbench.sv
